// ===== src/conductance_lif_adaptive_neuron_macros.svh =====
// Assertion macros shared by the neuron RTL.
// Depends on a clock named clk and an active-low reset named rst_n in scope.
`ifndef CONDUCTANCE_LIF_ADAPTIVE_NEURON_MACROS_SVH
`define CONDUCTANCE_LIF_ADAPTIVE_NEURON_MACROS_SVH

// Same-cycle implication, disabled during reset.
`define LIFN_ASSERT_IMPL(label, ante, cons, msg) \
    label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |-> (cons)) \
        else $error(msg);

// Next-cycle implication, disabled during reset.
`define LIFN_ASSERT_NEXT(label, ante, cons, msg) \
    label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |=> (cons)) \
        else $error(msg);

`endif

// ===== src/lifn_pkg.sv =====
// Shared types and constants for the conductance LIF neuron.
// No dependencies; used by lifn_div and the top level.
package lifn_pkg;

    // Fraction bits produced by the weight divider.
    localparam int DIV_STEPS = 16;

    // Divider request from the sequencer.
    typedef struct packed {
        logic start;
    } div_ctrl_t;

    // Divider status back to the sequencer.
    typedef struct packed {
        logic busy;
        logic done;
    } div_stat_t;

endpackage

// ===== src/lifn_mul.sv =====
// Shared signed multiplier with a registered product.
// No package dependencies; instantiated by the top level.
module lifn_mul #(
    parameter int AW = 19,
    parameter int BW = 23
) (
    input  logic                  clk,
    input  logic signed [AW-1:0]  a,
    input  logic signed [BW-1:0]  b,
    output logic signed [AW+BW-1:0] prod
);

    logic signed [AW+BW-1:0] prod_reg;

    // One product per cycle; the sequencer reads it in the next cycle.
    always_ff @(posedge clk)
    begin
        prod_reg <= a * b;
    end

    assign prod = prod_reg;

endmodule

// ===== src/lifn_div.sv =====
// Serial restoring divider giving floor(num * 2^16 / den) for num < den.
// Depends on lifn_pkg for the step count and the control structs.
module lifn_div #(
    parameter int DW = 18
) (
    input  logic                               clk,
    input  logic                               rst_n,
    input  lifn_pkg::div_ctrl_t                ctrl,
    input  logic [DW-1:0]                      num,
    input  logic [DW-1:0]                      den,
    output lifn_pkg::div_stat_t                stat,
    output logic [lifn_pkg::DIV_STEPS-1:0]     quo
);

    localparam int CW = $clog2(lifn_pkg::DIV_STEPS + 1);

    logic [DW-1:0]                  rem_reg;
    logic [DW-1:0]                  den_reg;
    logic [lifn_pkg::DIV_STEPS-1:0] quo_reg;
    logic [CW-1:0]                  cnt_reg;
    logic                           busy_reg;
    logic                           done_reg;
    logic [DW:0]                    rem2;
    logic [DW:0]                    diff;
    logic                           fits;

    // One quotient bit per cycle.
    assign rem2 = {rem_reg, 1'b0};
    assign diff = rem2 - {1'b0, den_reg};
    assign fits = rem2 >= {1'b0, den_reg};

    // Control state of the iteration.
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            busy_reg <= 1'b0;
            done_reg <= 1'b0;
            cnt_reg  <= '0;
        end
        else
        begin
            done_reg <= 1'b0;
            if (ctrl.start)
            begin
                busy_reg <= 1'b1;
                cnt_reg  <= CW'(lifn_pkg::DIV_STEPS);
            end
            else if (busy_reg)
            begin
                cnt_reg <= cnt_reg - CW'(1);
                if (cnt_reg == CW'(1))
                begin
                    busy_reg <= 1'b0;
                    done_reg <= 1'b1;
                end
            end
        end
    end

    // Remainder and quotient shift registers.
    always_ff @(posedge clk)
    begin
        if (ctrl.start)
        begin
            rem_reg <= num;
            den_reg <= den;
        end
        else if (busy_reg)
        begin
            rem_reg <= fits ? diff[DW-1:0] : rem2[DW-1:0];
            quo_reg <= {quo_reg[lifn_pkg::DIV_STEPS-2:0], fits};
        end
    end

    assign stat.busy = busy_reg;
    assign stat.done = done_reg;
    assign quo       = quo_reg;

endmodule

// ===== src/conductance_lif_adaptive_neuron.sv =====
// Top level of the conductance LIF neuron with adaptive threshold.
// Depends on lifn_pkg, lifn_mul, lifn_div and the assertion macro header.
//
// Usage. Each transaction on the s_ stream is one time step carrying the
// excitatory and inhibitory input weights. Each step produces exactly one
// transaction on the m_ stream with the spike flag, membrane, threshold
// term and running spike count. Registers are written through the cfg_
// channel, which is always ready; write only while the block is idle.
// Sequencing. A refractory step goes from idle straight to the threshold
// test and the output state. An integrating step runs its products
// through one shared multiplier, a five-pass Horner chain for the
// exponential and two serial divides for the conductance weights, the
// first of which overlaps the exponential. s_tready is high only while
// the sequencer is idle, so a new step waits until the last one is done.
// Stalls. The result sits in an output register, so a new step is accepted
// while the last result waits; the sequencer holds at its last state until
// m_tready frees the output register.
// Reset. rst_n is asynchronous, active low; it loads the register defaults,
// puts the membrane at rest and clears the other neuron and control state.
`include "conductance_lif_adaptive_neuron_macros.svh"
module conductance_lif_adaptive_neuron #(
    parameter int VALUE_WIDTH = 16,
    parameter int COUNT_WIDTH = 32
) (
    input  logic        clk,
    input  logic        rst_n,
    // Input step stream. s_tdata: excit_in, inhib_in.
    input  logic        s_tvalid,
    output logic        s_tready,
    input  logic [((2*VALUE_WIDTH+7)/8)*8-1:0] s_tdata,
    // Result stream. m_tdata: spike_out, membrane_out, theta_out, fired_total.
    output logic        m_tvalid,
    input  logic        m_tready,
    output logic [((1+2*VALUE_WIDTH+COUNT_WIDTH+7)/8)*8-1:0] m_tdata,
    // Register write channel.
    input  logic        cfg_valid,
    output logic        cfg_ready,
    input  logic [2:0]  cfg_index,
    input  logic [63:0] cfg_data
);

    localparam int W   = VALUE_WIDTH;
    localparam int C   = COUNT_WIDTH;
    localparam int OW  = ((1+2*W+C+7)/8)*8;
    localparam int GW  = W + 2;
    localparam int AW  = (W + 3 > 17) ? W + 3 : 17;
    localparam int BW  = 23;
    localparam int PW  = AW + BW;
    localparam int ACW = W + 19;
    localparam int FR  = lifn_pkg::DIV_STEPS;

    // Register indexes.
    localparam logic [2:0] CFG_REST  = 3'd0;
    localparam logic [2:0] CFG_EXC   = 3'd1;
    localparam logic [2:0] CFG_INH   = 3'd2;
    localparam logic [2:0] CFG_RESET = 3'd3;
    localparam logic [2:0] CFG_FIRE  = 3'd4;
    localparam logic [2:0] CFG_THSTP = 3'd5;
    localparam logic [2:0] CFG_REFR  = 3'd6;
    localparam logic [2:0] CFG_DECAY = 3'd7;

    // Register defaults.
    localparam logic [W-1:0] REST_RST  = W'(-16640);
    localparam logic [W-1:0] INH_RST   = W'(-25600);
    localparam logic [W-1:0] FIRE_RST  = W'(-18432);
    localparam logic [W-1:0] THSTP_RST = W'(13);

    // Fixed-point constants.
    localparam logic [16:0] ONE_Q15   = 17'd32768;
    localparam logic [16:0] LOG2E_Q15 = 17'd47274;
    localparam logic [16:0] LN2_Q15   = 17'd22713;
    localparam logic [16:0] RECIP3    = 17'd43691;
    localparam logic [16:0] RECIP5    = 17'd52429;
    localparam logic [20:0] X_CAP     = 21'h100000;
    localparam logic signed [PW-1:0]  VMAX_P = PW'({W{1'b1}});
    localparam logic signed [W+1:0]   SMAX_E = (W+2)'({1'b0, {(W-1){1'b1}}});
    localparam logic signed [W+1:0]   SMIN_E = -SMAX_E - (W+2)'(1);

    // Sequencer states.
    localparam logic [4:0] ST_IDLE = 5'd0;
    localparam logic [4:0] ST_GEM  = 5'd1;
    localparam logic [4:0] ST_GIM  = 5'd2;
    localparam logic [4:0] ST_FFE  = 5'd3;
    localparam logic [4:0] ST_FFI  = 5'd4;
    localparam logic [4:0] ST_XMUL = 5'd5;
    localparam logic [4:0] ST_X    = 5'd6;
    localparam logic [4:0] ST_Y    = 5'd7;
    localparam logic [4:0] ST_R    = 5'd8;
    localparam logic [4:0] ST_HST  = 5'd9;
    localparam logic [4:0] ST_HMUL = 5'd10;
    localparam logic [4:0] ST_HREC = 5'd11;
    localparam logic [4:0] ST_HUPD = 5'd12;
    localparam logic [4:0] ST_EXP  = 5'd13;
    localparam logic [4:0] ST_WE   = 5'd14;
    localparam logic [4:0] ST_WI   = 5'd15;
    localparam logic [4:0] ST_AR   = 5'd16;
    localparam logic [4:0] ST_AE   = 5'd17;
    localparam logic [4:0] ST_AI   = 5'd18;
    localparam logic [4:0] ST_ACC  = 5'd19;
    localparam logic [4:0] ST_VINF = 5'd20;
    localparam logic [4:0] ST_DMUL = 5'd21;
    localparam logic [4:0] ST_MEM  = 5'd22;
    localparam logic [4:0] ST_GE   = 5'd23;
    localparam logic [4:0] ST_GI   = 5'd24;
    localparam logic [4:0] ST_TH   = 5'd25;
    localparam logic [4:0] ST_TEST = 5'd26;
    localparam logic [4:0] ST_OUT  = 5'd27;

    // Configuration registers.
    logic signed [W-1:0] rest_reg, exc_rev_reg, inh_rev_reg, reset_lvl_reg, fire_base_reg;
    logic [W-1:0]        theta_step_reg;
    logic [7:0]          refr_len_reg;
    logic [63:0]         factors_reg;

    // Neuron state.
    logic signed [W-1:0] mem_reg;
    logic [W-1:0]        ge_reg, gi_reg, theta_reg;
    logic [7:0]          refr_reg;
    logic [C-1:0]        tally_reg;

    // Working registers.
    logic [4:0]          state_reg, state_next;
    logic [W-1:0]        gem_reg, gim_reg;
    logic [GW-1:0]       g_reg;
    logic [16:0]         ffe_reg, ffi_reg;
    logic [20:0]         x_reg;
    logic [5:0]          n_reg;
    logic [14:0]         r_reg;
    logic [15:0]         t_reg, e_reg, we_reg, wi_reg;
    logic [2:0]          k_reg;
    logic signed [ACW-1:0] acc_reg;
    logic signed [W-1:0] vinf_reg;
    logic                spike_reg;
    logic                out_valid_reg;
    logic [OW-1:0]       out_data_reg;

    // Shared units.
    logic signed [AW-1:0] mul_a;
    logic signed [BW-1:0] mul_b;
    logic signed [PW-1:0] prod;
    lifn_pkg::div_ctrl_t  div_ctrl;
    lifn_pkg::div_stat_t  div_stat;
    logic [GW-1:0]        div_num, div_den;
    logic [FR-1:0]        div_quo;

    // Derived values.
    logic [15:0]          fe, fi, f2, f3;
    logic [W-1:0]         excit_in, inhib_in;
    logic [W:0]           ge_sum, gi_sum, theta_sum;
    logic [GW-1:0]        g_comb;
    logic [16:0]          wr;
    logic [16:0]          h_recip;
    logic [4:0]           h_shift;
    logic [30:0]          h_quot;
    logic signed [PW-1:0] x_full;
    logic signed [W+1:0]  mem_sum;
    logic signed [W+1:0]  fire_level;
    logic                 in_acc, out_free, fire;

    assign fe = factors_reg[15:0];
    assign fi = factors_reg[31:16];
    assign f2 = factors_reg[47:32];
    assign f3 = factors_reg[63:48];
    assign excit_in = s_tdata[W-1:0];
    assign inhib_in = s_tdata[2*W-1:W];

    assign s_tready  = (state_reg == ST_IDLE);
    assign in_acc    = s_tvalid && s_tready;
    assign cfg_ready = 1'b1;
    assign out_free  = !out_valid_reg || m_tready;

    // Saturating Q1.15 scale of a nonnegative product.
    function automatic logic [W-1:0] sat_q15(input logic signed [PW-1:0] p);
        logic signed [PW-1:0] v;
        v = p >>> 15;
        if (v > VMAX_P)
            sat_q15 = {W{1'b1}};
        else
            sat_q15 = v[W-1:0];
    endfunction

    // Input accumulation into the conductances, saturating, plus derived sums and scales.
    assign ge_sum = {1'b0, ge_reg} + {1'b0, excit_in};
    assign gi_sum = {1'b0, gi_reg} + {1'b0, inhib_in};
    assign g_comb = GW'(256) + GW'(gem_reg) + GW'(gim_reg);
    assign wr     = ONE_Q15 + ONE_Q15 - 17'(we_reg) - 17'(wi_reg);
    assign x_full = prod >>> 8;

    // Divide by k in the Horner chain as a reciprocal product and shift.
    always_comb
    begin
        unique case (k_reg)
            3'd3:    begin h_recip = RECIP3;   h_shift = 5'd17; end
            3'd5:    begin h_recip = RECIP5;   h_shift = 5'd18; end
            3'd2:    begin h_recip = 17'd1;    h_shift = 5'd1;  end
            3'd4:    begin h_recip = 17'd1;    h_shift = 5'd2;  end
            default: begin h_recip = 17'd1;    h_shift = 5'd0;  end
        endcase
    end
    assign h_quot = prod[30:0] >> h_shift;

    // Relaxed membrane and threshold test.
    assign mem_sum    = (W+2)'(vinf_reg) + (W+2)'(prod >>> 15);
    assign fire_level = $signed({2'b00, theta_reg}) + (W+2)'(fire_base_reg);
    assign fire       = (refr_reg == 8'd0) && ((W+2)'(mem_reg) > fire_level);
    assign theta_sum  = {1'b0, theta_reg} + {1'b0, theta_step_reg};

    // Operand selection for the shared multiplier.
    always_comb
    begin
        mul_a = '0;
        mul_b = '0;
        unique case (state_reg)
            ST_GEM:  begin mul_a = AW'(ge_reg);          mul_b = BW'(fe);      end
            ST_GIM:  begin mul_a = AW'(gi_reg);          mul_b = BW'(fi);      end
            ST_FFE:  begin mul_a = AW'(fe);              mul_b = BW'(fe);      end
            ST_FFI:  begin mul_a = AW'(fi);              mul_b = BW'(fi);      end
            ST_XMUL: begin mul_a = AW'(g_reg);           mul_b = BW'(f3);      end
            ST_Y:    begin mul_a = AW'(LOG2E_Q15);       mul_b = BW'(x_reg);   end
            ST_R:    begin mul_a = AW'(prod[29:15]);     mul_b = BW'(LN2_Q15); end
            ST_HMUL: begin mul_a = AW'(r_reg);           mul_b = BW'(t_reg);   end
            ST_HREC: begin mul_a = AW'(prod[29:15]);     mul_b = BW'(h_recip); end
            ST_AR:   begin mul_a = AW'(rest_reg);        mul_b = BW'(wr);      end
            ST_AE:   begin mul_a = AW'(exc_rev_reg);     mul_b = BW'(we_reg);  end
            ST_AI:   begin mul_a = AW'(inh_rev_reg);     mul_b = BW'(wi_reg);  end
            ST_DMUL: begin mul_a = AW'(mem_reg) - AW'(vinf_reg); mul_b = BW'(e_reg); end
            ST_MEM:  begin mul_a = AW'(ge_reg);          mul_b = BW'(ffe_reg); end
            ST_GE:   begin mul_a = AW'(gi_reg);          mul_b = BW'(ffi_reg); end
            ST_GI:   begin mul_a = AW'(theta_reg);       mul_b = BW'(f2);      end
            default: begin mul_a = '0;                   mul_b = '0;           end
        endcase
    end

    // Divider requests: first the excitatory weight, then the inhibitory one.
    always_comb
    begin
        div_ctrl.start = 1'b0;
        div_num        = GW'(gem_reg);
        div_den        = g_comb;
        if (state_reg == ST_FFI)
        begin
            div_ctrl.start = 1'b1;
        end
        else if (state_reg == ST_WE && !div_stat.busy)
        begin
            div_ctrl.start = 1'b1;
            div_num        = GW'(gim_reg);
            div_den        = g_reg;
        end
    end

    // Sequencer transitions.
    always_comb
    begin
        state_next = state_reg;
        unique case (state_reg)
            ST_IDLE: if (in_acc) state_next = (refr_reg != 8'd0) ? ST_TEST : ST_GEM;
            ST_GEM:  state_next = ST_GIM;
            ST_GIM:  state_next = ST_FFE;
            ST_FFE:  state_next = ST_FFI;
            ST_FFI:  state_next = ST_XMUL;
            ST_XMUL: state_next = ST_X;
            ST_X:    state_next = ST_Y;
            ST_Y:    state_next = ST_R;
            ST_R:    state_next = ST_HST;
            ST_HST:  state_next = ST_HMUL;
            ST_HMUL: state_next = ST_HREC;
            ST_HREC: state_next = ST_HUPD;
            ST_HUPD: state_next = (k_reg == 3'd1) ? ST_EXP : ST_HMUL;
            ST_EXP:  state_next = ST_WE;
            ST_WE:   if (!div_stat.busy) state_next = ST_WI;
            ST_WI:   if (!div_stat.busy) state_next = ST_AR;
            ST_AR:   state_next = ST_AE;
            ST_AE:   state_next = ST_AI;
            ST_AI:   state_next = ST_ACC;
            ST_ACC:  state_next = ST_VINF;
            ST_VINF: state_next = ST_DMUL;
            ST_DMUL: state_next = ST_MEM;
            ST_MEM:  state_next = ST_GE;
            ST_GE:   state_next = ST_GI;
            ST_GI:   state_next = ST_TH;
            ST_TH:   state_next = ST_TEST;
            ST_TEST: state_next = ST_OUT;
            ST_OUT:  if (out_free) state_next = ST_IDLE;
            default: state_next = ST_IDLE;
        endcase
    end

    // Control, configuration and neuron state.
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg      <= ST_IDLE;
            rest_reg       <= REST_RST;
            exc_rev_reg    <= '0;
            inh_rev_reg    <= INH_RST;
            reset_lvl_reg  <= REST_RST;
            fire_base_reg  <= FIRE_RST;
            theta_step_reg <= THSTP_RST;
            refr_len_reg   <= 8'd50;
            factors_reg    <= '0;
            mem_reg        <= REST_RST;
            ge_reg         <= '0;
            gi_reg         <= '0;
            theta_reg      <= '0;
            refr_reg       <= '0;
            tally_reg      <= '0;
            out_valid_reg  <= 1'b0;
        end
        else
        begin
            state_reg <= state_next;

            // Register writes.
            if (cfg_valid && cfg_ready)
            begin
                unique case (cfg_index)
                    CFG_REST:  rest_reg       <= cfg_data[W-1:0];
                    CFG_EXC:   exc_rev_reg    <= cfg_data[W-1:0];
                    CFG_INH:   inh_rev_reg    <= cfg_data[W-1:0];
                    CFG_RESET: reset_lvl_reg  <= cfg_data[W-1:0];
                    CFG_FIRE:  fire_base_reg  <= cfg_data[W-1:0];
                    CFG_THSTP: theta_step_reg <= cfg_data[W-1:0];
                    CFG_REFR:  refr_len_reg   <= cfg_data[7:0];
                    CFG_DECAY: factors_reg    <= cfg_data;
                endcase
            end

            // Output register handshake.
            if (state_reg == ST_OUT && out_free)
                out_valid_reg <= 1'b1;
            else if (m_tready)
                out_valid_reg <= 1'b0;

            unique case (state_reg)
                ST_IDLE:
                begin
                    if (in_acc)
                    begin
                        ge_reg <= ge_sum[W] ? {W{1'b1}} : ge_sum[W-1:0];
                        gi_reg <= gi_sum[W] ? {W{1'b1}} : gi_sum[W-1:0];
                        if (refr_reg != 8'd0)
                            refr_reg <= refr_reg - 8'd1;
                    end
                end
                ST_MEM:
                begin
                    if (mem_sum > SMAX_E)
                        mem_reg <= SMAX_E[W-1:0];
                    else if (mem_sum < SMIN_E)
                        mem_reg <= SMIN_E[W-1:0];
                    else
                        mem_reg <= mem_sum[W-1:0];
                end
                ST_GE:   ge_reg <= sat_q15(prod);
                ST_GI:   gi_reg <= sat_q15(prod);
                ST_TH:
                begin
                    if (theta_step_reg != '0)
                        theta_reg <= sat_q15(prod);
                end
                ST_TEST:
                begin
                    if (fire)
                    begin
                        mem_reg   <= reset_lvl_reg;
                        refr_reg  <= refr_len_reg;
                        theta_reg <= theta_sum[W] ? {W{1'b1}} : theta_sum[W-1:0];
                        tally_reg <= tally_reg + C'(1);
                    end
                end
                default: ;
            endcase
        end
    end

    // Datapath working registers.
    always_ff @(posedge clk)
    begin
        unique case (state_reg)
            ST_GIM:  gem_reg <= sat_q15(prod);
            ST_FFE:  gim_reg <= sat_q15(prod);
            ST_FFI:
            begin
                ffe_reg <= prod[31:15];
                g_reg   <= g_comb;
            end
            ST_XMUL: ffi_reg <= prod[31:15];
            ST_X:    x_reg   <= (x_full > PW'(X_CAP)) ? X_CAP : x_full[20:0];
            ST_R:
            begin
                n_reg <= prod[35:30];
                t_reg <= ONE_Q15[15:0];
                k_reg <= 3'd5;
            end
            ST_HST:  r_reg <= prod[29:15];
            ST_HUPD:
            begin
                t_reg <= ONE_Q15[15:0] - h_quot[15:0];
                k_reg <= k_reg - 3'd1;
            end
            ST_EXP:  e_reg <= (n_reg >= 6'd16) ? 16'd0 : (t_reg >> n_reg[3:0]);
            ST_WE:   if (!div_stat.busy) we_reg <= div_quo;
            ST_WI:   if (!div_stat.busy) wi_reg <= div_quo;
            ST_AE:   acc_reg <= ACW'(prod);
            ST_AI:   acc_reg <= acc_reg + ACW'(prod);
            ST_ACC:  acc_reg <= acc_reg + ACW'(prod);
            ST_VINF: vinf_reg <= W'(acc_reg >>> 16);
            ST_TEST: spike_reg <= fire;
            ST_OUT:
            begin
                if (out_free)
                    out_data_reg <= OW'({tally_reg, theta_reg, mem_reg, spike_reg});
            end
            default: ;
        endcase
    end

    assign m_tvalid = out_valid_reg;
    assign m_tdata  = out_data_reg;

    lifn_mul #(.AW(AW), .BW(BW)) u_mul (
        .clk  (clk),
        .a    (mul_a),
        .b    (mul_b),
        .prod (prod)
    );

    lifn_div #(.DW(GW)) u_div (
        .clk   (clk),
        .rst_n (rst_n),
        .ctrl  (div_ctrl),
        .num   (div_num),
        .den   (div_den),
        .stat  (div_stat),
        .quo   (div_quo)
    );

    // A refractory step skips integration and goes straight to the test.
    `LIFN_ASSERT_NEXT(a_refr_skip, in_acc && (refr_reg != 8'd0), state_reg == ST_TEST, "refractory step integrated")
    // The divider is never restarted while it is still iterating.
    `LIFN_ASSERT_IMPL(a_div_free, div_ctrl.start, !div_stat.busy, "divider restarted while busy")
    // The divider is already idle when it reports completion and stays so unless restarted.
    `LIFN_ASSERT_NEXT(a_div_done, div_stat.done && !div_ctrl.start, !div_stat.busy, "divider stayed busy")
    // A spike always reloads the refractory timer.
    `LIFN_ASSERT_IMPL(a_spike_timer, (state_reg == ST_OUT) && spike_reg, refr_reg == refr_len_reg, "timer not loaded on spike")

endmodule

// ===== dv/testbench.sv =====
// Self-checking bench for the conductance LIF neuron with adaptive threshold.
// Needs only the neuron RTL; predicts each step and compares the result stream.
`timescale 1ns / 100ps
module testbench;

    localparam int VW = 16;
    localparam int CW = 32;

    // Register indexes.
    typedef enum logic [2:0] {
        REG_REST = 3'd0, REG_EXC_REV = 3'd1, REG_INH_REV = 3'd2, REG_RESET = 3'd3,
        REG_FIRE_BASE = 3'd4, REG_THETA_STEP = 3'd5, REG_REFRACT = 3'd6, REG_DECAY = 3'd7
    } reg_index_t;

    typedef struct {
        bit             spike;
        logic [VW-1:0]  membrane;
        logic [VW-1:0]  theta;
        logic [CW-1:0]  tally;
    } step_result_t;

    logic        clk;
    logic        rst_n;
    logic        s_tvalid;
    logic        s_tready;
    // s_tdata fields from bit 0: excit_in, inhib_in.
    logic [31:0] s_tdata;
    logic        m_tvalid;
    logic        m_tready;
    // m_tdata fields from bit 0: spike_out, membrane_out, theta_out, fired_total.
    logic [71:0] m_tdata;
    logic        cfg_valid;
    logic        cfg_ready;
    logic [2:0]  cfg_index;
    logic [63:0] cfg_data;

    // Predictor copy of registers and neuron state.
    longint rest_lv, exc_rev, inh_rev, reset_lv, fire_base;
    longint theta_step, refract_len;
    logic [63:0] decay_f;
    longint membrane_st, excit_g, inhib_g, theta_st, refract_left, tally_st;

    step_result_t expected_steps[$];
    int  errors;
    int  send_idle_pct;
    int  recv_stall_pct;
    bit  long_hold;

    conductance_lif_adaptive_neuron dut (
        .clk(clk), .rst_n(rst_n),
        .s_tvalid(s_tvalid), .s_tready(s_tready), .s_tdata(s_tdata),
        .m_tvalid(m_tvalid), .m_tready(m_tready), .m_tdata(m_tdata),
        .cfg_valid(cfg_valid), .cfg_ready(cfg_ready),
        .cfg_index(cfg_index), .cfg_data(cfg_data)
    );

    // Clock generation.
    always
    begin
        clk = 1'b1;
        #6;
        clk = 1'b0;
        #6;
    end

    function automatic longint sext16(longint u);
        u = u & 64'hFFFF;
        return (u >= 32768) ? u - 65536 : u;
    endfunction

    function automatic longint clamp_s(longint x);
        if (x > 32767) return 32767;
        if (x < -32768) return -32768;
        return x;
    endfunction

    function automatic longint clamp_u(longint x);
        return (x > 65535) ? 65535 : x;
    endfunction

    // Floor division by a power of two for signed values.
    function automatic longint floor_div2(longint x, int n);
        if (x >= 0) return x >>> n;
        return -((-x + ((longint'(1) << n) - 1)) >>> n);
    endfunction

    function automatic longint q15_factor(int k);
        return longint'((decay_f >> (16 * k)) & 64'hFFFF);
    endfunction

    // exp(-x) for x in Q.15, result in Q1.15.
    function automatic longint exp_decay(longint x);
        longint y, n, r, t;
        if (x > (longint'(1) << 20)) x = longint'(1) << 20;
        y = (x * 47274) >>> 15;
        n = y >>> 15;
        if (n >= 16) return 0;
        r = ((y & 32767) * 22713) >>> 15;
        t = 32768;
        for (int k = 5; k >= 1; k--)
            t = 32768 - (r * t) / (k * 32768);
        return t >>> n;
    endfunction

    // Advance the neuron by one time step and queue the result.
    function automatic void predict_step(longint exc_w, longint inh_w);
        longint fe, fi, gem, gim, g, we, wi, wr, acc, vinf, e;
        step_result_t res;
        res.spike = 1'b0;
        excit_g = clamp_u(excit_g + exc_w);
        inhib_g = clamp_u(inhib_g + inh_w);
        if (refract_left > 0)
        begin
            refract_left--;
        end
        else
        begin
            fe = q15_factor(0);
            fi = q15_factor(1);
            gem = clamp_u((excit_g * fe) >>> 15);
            gim = clamp_u((inhib_g * fi) >>> 15);
            g = 256 + gem + gim;
            we = (gem << 16) / g;
            wi = (gim << 16) / g;
            wr = 65536 - we - wi;
            acc = rest_lv * wr + exc_rev * we + inh_rev * wi;
            vinf = floor_div2(acc, 16);
            e = exp_decay((q15_factor(3) * g) >>> 8);
            membrane_st = clamp_s(vinf + floor_div2((membrane_st - vinf) * e, 15));
            excit_g = clamp_u((excit_g * ((fe * fe) >>> 15)) >>> 15);
            inhib_g = clamp_u((inhib_g * ((fi * fi) >>> 15)) >>> 15);
            if (theta_step != 0)
                theta_st = clamp_u((theta_st * q15_factor(2)) >>> 15);
        end
        if (refract_left == 0 && membrane_st > theta_st + fire_base)
        begin
            res.spike = 1'b1;
            membrane_st = reset_lv;
            refract_left = refract_len;
            theta_st = clamp_u(theta_st + theta_step);
            tally_st = (tally_st + 1) & 64'hFFFFFFFF;
        end
        res.membrane = membrane_st[VW-1:0];
        res.theta = theta_st[VW-1:0];
        res.tally = tally_st[CW-1:0];
        expected_steps.push_back(res);
    endfunction

    // Write one register and mirror it in the predictor.
    task automatic write_reg(reg_index_t idx, logic [63:0] value);
        cfg_valid <= 1'b1;
        cfg_index <= idx;
        cfg_data <= value;
        @(posedge clk);
        while (!cfg_ready) @(posedge clk);
        cfg_valid <= 1'b0;
        @(posedge clk);
        case (idx)
            REG_REST:       rest_lv = sext16(value);
            REG_EXC_REV:    exc_rev = sext16(value);
            REG_INH_REV:    inh_rev = sext16(value);
            REG_RESET:      reset_lv = sext16(value);
            REG_FIRE_BASE:  fire_base = sext16(value);
            REG_THETA_STEP: theta_step = longint'(value[15:0]);
            REG_REFRACT:    refract_len = longint'(value[7:0]);
            default:        decay_f = value;
        endcase
    endtask

    // Offer one step and hold it until accepted.
    task automatic send_step(logic [15:0] exc_w, logic [15:0] inh_w);
        while ($urandom_range(99) < send_idle_pct) @(posedge clk);
        s_tvalid <= 1'b1;
        s_tdata <= {inh_w, exc_w};
        @(posedge clk);
        while (!s_tready) @(posedge clk);
        predict_step(exc_w, inh_w);
        s_tvalid <= 1'b0;
        @(posedge clk);
    endtask

    // Wait for every result, then let the sequencer settle.
    task automatic drain();
        while (expected_steps.size() != 0) @(posedge clk);
        repeat (80) @(posedge clk);
    endtask

    // Receiver backpressure.
    always @(posedge clk)
    begin
        if (long_hold)
            m_tready <= 1'b0;
        else
            m_tready <= ($urandom_range(99) >= recv_stall_pct);
    end

    // Compare each accepted result with the oldest prediction.
    always @(posedge clk)
    begin
        step_result_t exp_r;
        if (rst_n && m_tvalid && m_tready)
        begin
            if (expected_steps.size() == 0)
            begin
                $error("unexpected result transaction");
                errors++;
            end
            else
            begin
                exp_r = expected_steps.pop_front();
                if (m_tdata[0] !== exp_r.spike)
                begin
                    $error("spike_out expected %0d got %0d", exp_r.spike, m_tdata[0]);
                    errors++;
                end
                if (m_tdata[16:1] !== exp_r.membrane)
                begin
                    $error("membrane_out expected %0d got %0d",
                           $signed(exp_r.membrane), $signed(m_tdata[16:1]));
                    errors++;
                end
                if (m_tdata[32:17] !== exp_r.theta)
                begin
                    $error("theta_out expected %0d got %0d", exp_r.theta, m_tdata[32:17]);
                    errors++;
                end
                if (m_tdata[64:33] !== exp_r.tally)
                begin
                    $error("fired_total expected %0d got %0d", exp_r.tally, m_tdata[64:33]);
                    errors++;
                end
            end
        end
    end

    // Typical decay factors: half-step decays near 0.9, dt/tau near 0.05.
    function automatic logic [63:0] rand_decay();
        return {16'($urandom_range(4000)), 16'($urandom_range(28000, 32768)),
                16'($urandom_range(20000, 32768)), 16'($urandom_range(20000, 32768))};
    endfunction

    task automatic test_reset_defaults();
        // Default factors are zero: conductances vanish, membrane holds at rest.
        send_step(16'h0000, 16'h0000);
        send_step(16'hFFFF, 16'hFFFF);
        send_step(16'h0100, 16'h0000);
        drain();
    endtask

    task automatic test_extremes();
        write_reg(REG_DECAY, 64'h0CCD_7F00_7800_7800);
        write_reg(REG_THETA_STEP, 16'd200);
        write_reg(REG_REFRACT, 8'd0);
        write_reg(REG_FIRE_BASE, 16'hB800);
        // Saturated input and back-to-back firing with no refractory period.
        send_step(16'hFFFF, 16'h0000);
        send_step(16'hFFFF, 16'h0000);
        send_step(16'hFFFF, 16'hFFFF);
        send_step(16'h0000, 16'hFFFF);
        send_step(16'h8000, 16'h0001);
        send_step(16'h5555, 16'hAAAA);
        send_step(16'hAAAA, 16'h5555);
        drain();
        // Extreme register values, plasticity off, maximum dt/tau.
        write_reg(REG_REST, 16'h7FFF);
        write_reg(REG_EXC_REV, 16'h8000);
        write_reg(REG_INH_REV, 16'h7FFF);
        write_reg(REG_RESET, 16'h8000);
        write_reg(REG_THETA_STEP, 16'd0);
        write_reg(REG_DECAY, 64'hFFFF_FFFF_FFFF_FFFF);
        write_reg(REG_REFRACT, 8'd255);
        repeat (4) send_step(16'hFFFF, 16'hFFFF);
        drain();
        // Short refractory period exercises the timer-expiry threshold test.
        write_reg(REG_REFRACT, 8'd2);
        write_reg(REG_FIRE_BASE, 16'h8000);
        write_reg(REG_THETA_STEP, 16'hFFFF);
        repeat (6) send_step(16'h0000, 16'h0000);
        drain();
    endtask

    task automatic test_random_phase(int n_items);
        write_reg(REG_REST, 16'($urandom_range(16384) - 24576));
        write_reg(REG_EXC_REV, 16'($urandom_range(4096)));
        write_reg(REG_INH_REV, 16'($urandom_range(8192) - 28672));
        write_reg(REG_RESET, 16'($urandom_range(8192) - 24576));
        write_reg(REG_FIRE_BASE, 16'($urandom_range(8192) - 22528));
        write_reg(REG_THETA_STEP, ($urandom_range(3) == 0) ? 16'd0 : 16'($urandom));
        write_reg(REG_REFRACT, 8'($urandom_range(($urandom_range(1) == 0) ? 4 : 255)));
        write_reg(REG_DECAY, ($urandom_range(7) == 0) ? {$urandom, $urandom} : rand_decay());
        for (int i = 0; i < n_items; i++)
        begin
            if ($urandom_range(9) == 0)
                send_step(16'($urandom), 16'($urandom));
            else
                send_step(16'($urandom_range(2048)), 16'($urandom_range(1024)));
        end
        drain();
    endtask

    task automatic test_long_stall();
        long_hold = 1'b1;
        fork
            begin
                repeat (400) @(posedge clk);
                long_hold = 1'b0;
            end
            for (int i = 0; i < 6; i++) send_step(16'($urandom_range(4096)), 16'h0010);
        join
        drain();
    endtask

    // Main sequence.
    initial
    begin
        errors = 0;
        send_idle_pct = 0;
        recv_stall_pct = 0;
        long_hold = 1'b0;
        rst_n = 1'b0;
        s_tvalid = 1'b0;
        s_tdata = '0;
        cfg_valid = 1'b0;
        cfg_index = REG_REST;
        cfg_data = '0;
        rest_lv = -16640; exc_rev = 0; inh_rev = -25600; reset_lv = -16640;
        fire_base = -18432; theta_step = 13; refract_len = 50; decay_f = '0;
        membrane_st = -16640; excit_g = 0; inhib_g = 0; theta_st = 0;
        refract_left = 0; tally_st = 0;
        repeat (10) @(posedge clk);
        rst_n <= 1'b1;
        @(posedge clk);
        test_reset_defaults();
        test_extremes();
        test_long_stall();
        for (int p = 0; p < 8; p++)
        begin
            case (p % 4)
                0: begin send_idle_pct = 0;  recv_stall_pct = 0;  end
                1: begin send_idle_pct = 50; recv_stall_pct = 0;  end
                2: begin send_idle_pct = 0;  recv_stall_pct = 50; end
                default: begin send_idle_pct = 13; recv_stall_pct = 13; end
            endcase
            test_random_phase(160);
        end
        if (errors == 0)
            $display("PASSED: all results match");
        else
            $display("FAILED: results differ");
        $finish;
    end

    // Watchdog.
    initial
    begin
        #20ms;
        $display("FAILED: results differ");
        $finish;
    end

endmodule
